### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the dual-lane hash.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that the property holds at every clock edge out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check of an implication from a trigger to a consequence.
`define ASSERT_IMPL(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

`endif

### rtl/dlf_pkg.sv
// Package for the dual-lane FNV-1a hash: field widths, lane constants and
// the control struct of the digest stage. No dependencies.
package dlf_pkg;

    localparam int BYTE_W = 8;
    localparam int LANE_W = 64;
    localparam int FOLD_SHIFT = 32;

    localparam logic [LANE_W-1:0] UPPER_BASIS = 64'd14695981039346656037;
    localparam logic [LANE_W-1:0] LOWER_BASIS = 64'd7809847782465536322;
    localparam logic [BYTE_W-1:0] LOWER_TWEAK = 8'hA5;

    // Control from the absorb stage to the digest output register.
    typedef struct packed {
        logic load;
        logic take;
    } dlf_out_ctrl_t;

endpackage

### rtl/dlf_byte_if.sv
// Request channel that carries one message byte and its last marker.
// Depends on dlf_pkg for the byte width.
interface dlf_byte_if import dlf_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/dlf_digest_if.sv
// Request channel that carries one 128-bit digest as two 64-bit words.
// Depends on dlf_pkg for the lane width.
interface dlf_digest_if import dlf_pkg::*;;
    logic              valid;
    logic              ready;
    logic [LANE_W-1:0] digest_upper;
    logic [LANE_W-1:0] digest_lower;

    modport source (output valid, output digest_upper, output digest_lower, input ready);
    modport sink   (input valid, input digest_upper, input digest_lower, output ready);
endinterface

### rtl/dlf_absorb.sv
// Combinational absorb of one byte into both hash lanes.
// Depends on dlf_pkg for widths and the lower-lane tweak.
module dlf_absorb import dlf_pkg::*;
(
    input  logic [BYTE_W-1:0] data_byte,
    input  logic [LANE_W-1:0] upper_lane,
    input  logic [LANE_W-1:0] lower_lane,
    output logic [LANE_W-1:0] upper_next,
    output logic [LANE_W-1:0] lower_next
);

    // Multiply by the FNV prime 2^40 + 2^8 + 0xB3 modulo 2^64 as shift-adds.
    function automatic logic [LANE_W-1:0] fnv_mul(input logic [LANE_W-1:0] x);
        logic [LANE_W-1:0] sum;
        begin
            sum = (x << 40) + (x << 8) + (x << 7) + (x << 5)
                + (x << 4) + (x << 1) + x;
            return sum;
        end
    endfunction

    logic [LANE_W-1:0] upper_mix;
    logic [LANE_W-1:0] lower_mix;
    logic [LANE_W-1:0] lower_prod;

    // Upper lane is plain FNV-1a.
    assign upper_mix  = upper_lane ^ {{(LANE_W-BYTE_W){1'b0}}, data_byte};
    assign upper_next = fnv_mul(upper_mix);

    // Lower lane takes the tweaked byte, then folds its top half into the bottom.
    assign lower_mix  = lower_lane ^ {{(LANE_W-BYTE_W){1'b0}}, data_byte ^ LOWER_TWEAK};
    assign lower_prod = fnv_mul(lower_mix);
    assign lower_next = lower_prod ^ {{FOLD_SHIFT{1'b0}}, lower_prod[LANE_W-1:FOLD_SHIFT]};

endmodule

### rtl/dlf_out_stage.sv
// Digest output register with valid flag and the zero-digest fix-up.
// Depends on dlf_pkg for the lane width and the control struct.
module dlf_out_stage import dlf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dlf_out_ctrl_t     ctrl,
    input  logic [LANE_W-1:0] upper_in,
    input  logic [LANE_W-1:0] lower_in,
    output logic              valid,
    output logic [LANE_W-1:0] upper_out,
    output logic [LANE_W-1:0] lower_out
);

    logic              valid_reg;
    logic              valid_next;
    logic [LANE_W-1:0] upper_reg;
    logic [LANE_W-1:0] lower_reg;
    logic [LANE_W-1:0] lower_fixed;

    // An all-zero digest reports its low word as one.
    assign lower_fixed = ((upper_in == '0) && (lower_in == '0))
                       ? {{(LANE_W-1){1'b0}}, 1'b1} : lower_in;

    // Valid sets on a load and clears when the receiver takes the request.
    always_comb
    begin
        priority if (ctrl.load)
            valid_next = 1'b1;
        else if (ctrl.take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            upper_reg <= upper_in;
            lower_reg <= lower_fixed;
        end
    end

    assign valid     = valid_reg;
    assign upper_out = upper_reg;
    assign lower_out = lower_reg;

endmodule

### rtl/dual_lane_fnv1a_hash.sv
// Top level of the dual-lane FNV-1a 128-bit streaming hash.
// Depends on dlf_pkg, dlf_byte_if, dlf_digest_if, dlf_absorb, dlf_out_stage
// and assert_macros.svh.
//
// Usage:
//   message is the byte request channel: data_byte plus last_byte, which marks
//   the final byte of a message. digest is the result channel: one request
//   of digest_upper and digest_lower per message, sent after its last byte.
//   A byte is taken into an input register and absorbed into both lanes
//   from there, and when it is the last byte the digest is loaded into the
//   output register at that same edge, which sets digest valid.
//   Throughput is one byte per cycle unless a last byte waits on a held digest;
//   the rate is set by the lane update, whose shift-add multiply by the FNV prime is combinational.
//   Reset puts both lanes at their offset bases and empties both registers.
//   While the receiver stalls with a digest waiting, ordinary bytes keep
//   flowing; a following last byte waits in the input register until the
//   digest register frees, and message.ready is low only while it waits.
`include "assert_macros.svh"

module dual_lane_fnv1a_hash import dlf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    dlf_byte_if.sink            message,
    dlf_digest_if.source        digest
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;
    logic [LANE_W-1:0] upper_lane_reg;
    logic [LANE_W-1:0] upper_lane_next;
    logic [LANE_W-1:0] lower_lane_reg;
    logic [LANE_W-1:0] lower_lane_next;
    logic [LANE_W-1:0] upper_abs;
    logic [LANE_W-1:0] lower_abs;
    logic              advance;
    logic              accept;
    dlf_out_ctrl_t     out_ctrl;

    // The held byte moves on unless it is a last byte blocked by a waiting digest.
    assign advance = in_valid_reg && (!in_last_reg || !digest.valid || digest.ready);
    assign message.ready = !in_valid_reg || advance;
    assign accept = message.valid && message.ready;

    assign out_ctrl.load = advance && in_last_reg;
    assign out_ctrl.take = digest.valid && digest.ready;

    // Input register control.
    always_comb
    begin
        priority if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= message.data_byte;
            in_last_reg <= message.last_byte;
        end
    end

    // Absorb datapath.
    dlf_absorb u_absorb (
        .data_byte  (in_byte_reg),
        .upper_lane (upper_lane_reg),
        .lower_lane (lower_lane_reg),
        .upper_next (upper_abs),
        .lower_next (lower_abs)
    );

    // Lanes update on each advance and return to the bases after a last byte.
    always_comb
    begin
        upper_lane_next = upper_lane_reg;
        lower_lane_next = lower_lane_reg;
        if (advance)
        begin
            if (in_last_reg)
            begin
                upper_lane_next = UPPER_BASIS;
                lower_lane_next = LOWER_BASIS;
            end
            else
            begin
                upper_lane_next = upper_abs;
                lower_lane_next = lower_abs;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_lane_reg <= UPPER_BASIS;
            lower_lane_reg <= LOWER_BASIS;
        end
        else
        begin
            upper_lane_reg <= upper_lane_next;
            lower_lane_reg <= lower_lane_next;
        end
    end

    // Digest output register.
    dlf_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (out_ctrl),
        .upper_in  (upper_abs),
        .lower_in  (lower_abs),
        .valid     (digest.valid),
        .upper_out (digest.digest_upper),
        .lower_out (digest.digest_lower)
    );

    // Checks.
    `ASSERT_IMPL(a_load_needs_room, out_ctrl.load, !digest.valid || digest.ready, "digest overwritten while waiting")
    `ASSERT_IMPL(a_bases_after_digest, $past(out_ctrl.load), (upper_lane_reg == UPPER_BASIS) && (lower_lane_reg == LOWER_BASIS), "lanes not restarted after digest")
    `ASSERT_IMPL(a_digest_nonzero, digest.valid, (digest.digest_upper != '0) || (digest.digest_lower != '0), "all-zero digest sent")
    `ASSERT_IMPL(a_ready_when_empty, !in_valid_reg, message.ready, "input register empty but not ready")

endmodule

### tb/sv/dual_lane_fnv1a_hash_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the dual-lane FNV-1a 128-bit streaming hash.
// Depends on dlf_pkg, dlf_byte_if, dlf_digest_if and dual_lane_fnv1a_hash.
module dual_lane_fnv1a_hash_tb;
    import dlf_pkg::*;

    localparam logic [LANE_W-1:0] FNV_PRIME = 64'd1099511628211;
    localparam int STIM_BYTES = 540;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        bit                drain_first;
    } msg_byte_t;

    typedef struct {
        logic [LANE_W-1:0] upper;
        logic [LANE_W-1:0] lower;
    } digest_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dlf_byte_if   msg_if ();
    dlf_digest_if dig_if ();

    dual_lane_fnv1a_hash DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .message (msg_if),
        .digest  (dig_if)
    );

    // Bytes still to be offered, and digests still owed by the block.
    msg_byte_t byte_stream[$];
    digest_t   pending_digests[$];

    // Our own copy of the two hash lanes.
    logic [LANE_W-1:0] upper_acc;
    logic [LANE_W-1:0] lower_acc;

    int    errors = 0;
    int    bytes_taken = 0;
    int    digests_seen = 0;
    int    cycle_count = 0;
    bit    byte_taken = 1'b0;

    // Sender burst state.
    int    burst_left = 1;
    int    gap_left = 0;

    // Receiver state.
    int    hold_left = 0;
    int    holds_done = 0;
    int    hold_at = 8;
    int    ready_mode = 0;
    int    mode_left = 0;
    logic [7:0] ready_pattern = 8'hFF;

    // Clock generation.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Absorb one byte into both predicted lanes.
    task automatic absorb_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] tweaked;
        tweaked = b ^ LOWER_TWEAK;
        upper_acc = (upper_acc ^ {{(LANE_W-BYTE_W){1'b0}}, b}) * FNV_PRIME;
        lower_acc = (lower_acc ^ {{(LANE_W-BYTE_W){1'b0}}, tweaked}) * FNV_PRIME;
        lower_acc = lower_acc ^ (lower_acc >> FOLD_SHIFT);
    endtask

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what);
        $display("MISMATCH %s", what);
        errors++;
    endtask

    // Queue one message; the last byte carries the marker.
    task automatic add_message(input int len, input bit drain);
        msg_byte_t item;
        for (int i = 0; i < len; i++)
        begin
            item.data = BYTE_W'($urandom_range(0, 255));
            item.last = (i == len - 1);
            item.drain_first = drain && (i == 0);
            byte_stream.push_back(item);
        end
    endtask

    task automatic add_byte(input logic [BYTE_W-1:0] data, input logic last);
        msg_byte_t item;
        item.data = data;
        item.last = last;
        item.drain_first = 1'b0;
        byte_stream.push_back(item);
    endtask

    // Monitor: check digests against the oldest prediction, then predict
    // from the byte taken at this edge.
    always @(posedge clk)
    begin
        digest_t want;
        if (!rst_n)
        begin
            byte_taken = 1'b0;
        end
        else
        begin
            if (dig_if.valid && dig_if.ready)
            begin
                if (pending_digests.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected digest %h_%h",
                                              dig_if.digest_upper, dig_if.digest_lower));
                end
                else
                begin
                    want = pending_digests.pop_front();
                    if (dig_if.digest_upper !== want.upper)
                        report_mismatch($sformatf("digest %0d upper: got %h expected %h",
                                                  digests_seen, dig_if.digest_upper,
                                                  want.upper));
                    if (dig_if.digest_lower !== want.lower)
                        report_mismatch($sformatf("digest %0d lower: got %h expected %h",
                                                  digests_seen, dig_if.digest_lower,
                                                  want.lower));
                end
                digests_seen <= digests_seen + 1;
            end
            byte_taken = msg_if.valid && msg_if.ready;
            if (byte_taken)
            begin
                bytes_taken++;
                absorb_byte(msg_if.data_byte);
                if (msg_if.last_byte)
                begin
                    want.upper = upper_acc;
                    want.lower = lower_acc;
                    if (upper_acc == '0 && lower_acc == '0)
                        want.lower = 64'd1;
                    pending_digests.push_back(want);
                    upper_acc = UPPER_BASIS;
                    lower_acc = LOWER_BASIS;
                end
            end
        end
    end

    // Driver: offers bytes in bursts with random gaps between them.
    always @(negedge clk)
    begin
        if (rst_n && (byte_taken || !msg_if.valid))
        begin
            if (gap_left > 0 || byte_stream.size() == 0 ||
                (byte_stream[0].drain_first && pending_digests.size() != 0))
            begin
                if (gap_left > 0)
                    gap_left--;
                msg_if.valid <= 1'b0;
                msg_if.data_byte <= BYTE_W'($urandom_range(0, 255));
                msg_if.last_byte <= 1'($urandom_range(0, 1));
            end
            else
            begin
                msg_if.valid <= 1'b1;
                msg_if.data_byte <= byte_stream[0].data;
                msg_if.last_byte <= byte_stream[0].last;
                void'(byte_stream.pop_front());
                burst_left--;
                if (burst_left <= 0)
                begin
                    // A quarter of the bursts are long and run back to back.
                    if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = $urandom_range(30, 60);
                        gap_left = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = $urandom_range(0, 6);
                    end
                end
            end
        end
    end

    // Long receiver holds, started after a number of digests have come.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
            end
            else if (holds_done < 2 && digests_seen >= hold_at)
            begin
                hold_left <= HOLD_CYCLES;
                holds_done <= holds_done + 1;
                hold_at <= hold_at + 30;
            end
        end
    end

    // Receiver ready: switches among always ready, random and a rotating pattern.
    always @(negedge clk)
    begin
        logic rdy;
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 80);
                ready_pattern = 8'($urandom_range(0, 255)) | 8'h01;
            end
            else
            begin
                mode_left--;
            end
            case (ready_mode)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 3) != 0);
                default:
                begin
                    rdy = ready_pattern[0];
                    ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
                end
            endcase
            dig_if.ready <= rdy && (hold_left == 0);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digests outstanding",
                     cycle_count, pending_digests.size());
            $display("dual_lane_fnv1a_hash_tb NOT OK");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int len;
        msg_if.valid = 1'b0;
        msg_if.data_byte = '0;
        msg_if.last_byte = 1'b0;
        dig_if.ready = 1'b0;
        upper_acc = UPPER_BASIS;
        lower_acc = LOWER_BASIS;

        // Directed: single-byte messages at the byte extremes, the tweak value and its inverse.
        add_byte(8'h00, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_byte(8'hA5, 1'b1);
        add_byte(8'h5A, 1'b1);
        // A short message mixing extremes.
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'hA5, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h01, 1'b1);
        // Walking one across a message.
        for (int i = 0; i < BYTE_W; i++)
            add_byte(8'h01 << i, (i == BYTE_W - 1));
        // Repeated all-ones bytes, then a message right after a digest.
        for (int i = 0; i < 4; i++)
            add_byte(8'hFF, (i == 3));
        add_byte(8'h00, 1'b1);

        // Random messages, mostly short; pause for a full drain at the first one and near byte 300.
        while (byte_stream.size() < STIM_BYTES)
        begin
            case ($urandom_range(0, 19))
                0:           len = $urandom_range(25, 64);
                1, 2, 3, 4, 5: len = $urandom_range(9, 24);
                default:     len = $urandom_range(1, 8);
            endcase
            add_message(len, byte_stream.size() == 22 ||
                        (byte_stream.size() >= 300 && byte_stream.size() < 300 + len));
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every byte to be taken and every digest to arrive.
        while (byte_stream.size() != 0 || msg_if.valid)
            @(posedge clk);
        while (pending_digests.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Run covered %0d bytes and %0d digests with %0d long receiver holds",
                 bytes_taken, digests_seen, holds_done);
        $display("under bursty input, random output stalls and %0d mismatches.", errors);
        if (errors == 0)
            $display("dual_lane_fnv1a_hash_tb OK");
        else
            $display("dual_lane_fnv1a_hash_tb NOT OK");
        $finish;
    end

endmodule
